// File: rtl/lccd_pkg.sv
// ----------------------------------------------------------------------------
// lccd_pkg: linear CCD readout sequencer definitions
// Phase codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lccd_pkg;

	localparam int COUNT_WIDTH_DEF = 12;
	localparam int SEG_W           = 8;
	localparam int SIG_W           = 12;
	localparam int PIX_W           = 12;
	localparam int SAMPLE_W        = 16;
	localparam int PHASE_W         = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEAD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIELDED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRAIL    = 3'd4;

	// register reset values
	localparam logic [SEG_W-1:0] LEAD_RST     = 8'd16;
	localparam logic [SEG_W-1:0] SHIELDED_RST = 8'd13;
	localparam logic [SEG_W-1:0] HEADER_RST   = 8'd3;
	localparam logic [SIG_W-1:0] SIGNAL_RST   = 12'd3648;
	localparam logic [SEG_W-1:0] TRAIL_RST    = 8'd14;

	// item kinds
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// external phase codes
	localparam logic [PHASE_W-1:0] PHC_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PHC_BEGIN    = 4'd1;
	localparam logic [PHASE_W-1:0] PHC_ACTIVE   = 4'd2;
	localparam logic [PHASE_W-1:0] PHC_DUMMY    = 4'd3;
	localparam logic [PHASE_W-1:0] PHC_SHIELDED = 4'd4;
	localparam logic [PHASE_W-1:0] PHC_HEADER   = 4'd5;
	localparam logic [PHASE_W-1:0] PHC_SIGNAL   = 4'd6;
	localparam logic [PHASE_W-1:0] PHC_TRAIL    = 4'd7;
	localparam logic [PHASE_W-1:0] PHC_INTEG    = 4'd8;
	localparam logic [PHASE_W-1:0] PHC_FINISH   = 4'd9;

	typedef enum logic [9:0] {
		PH_IDLE     = 10'b00_0000_0001,
		PH_BEGIN    = 10'b00_0000_0010,
		PH_ACTIVE   = 10'b00_0000_0100,
		PH_DUMMY    = 10'b00_0000_1000,
		PH_SHIELDED = 10'b00_0001_0000,
		PH_HEADER   = 10'b00_0010_0000,
		PH_SIGNAL   = 10'b00_0100_0000,
		PH_TRAIL    = 10'b00_1000_0000,
		PH_INTEG    = 10'b01_0000_0000,
		PH_FINISH   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [SEG_W-1:0] lead;
		logic [SEG_W-1:0] shielded;
		logic [SEG_W-1:0] header;
		logic [SIG_W-1:0] signal;
		logic [SEG_W-1:0] trail;
	} cfg_t;

	typedef struct packed {
		logic                icg;
		logic                illum;
		logic [PHASE_W-1:0]  phase;
		logic                pix_valid;
		logic [PIX_W-1:0]    pix_index;
		logic [SAMPLE_W-1:0] pix_value;
		logic                done;
	} result_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		case (ph)
			PH_IDLE:     code = PHC_IDLE;
			PH_BEGIN:    code = PHC_BEGIN;
			PH_ACTIVE:   code = PHC_ACTIVE;
			PH_DUMMY:    code = PHC_DUMMY;
			PH_SHIELDED: code = PHC_SHIELDED;
			PH_HEADER:   code = PHC_HEADER;
			PH_SIGNAL:   code = PHC_SIGNAL;
			PH_TRAIL:    code = PHC_TRAIL;
			PH_INTEG:    code = PHC_INTEG;
			PH_FINISH:   code = PHC_FINISH;
			default:     code = PHC_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// File: rtl/lccd_seq.sv
// ----------------------------------------------------------------------------
// lccd_seq: phase sequencer and segment counter
// Holds phase, segment count, ICG and illuminator state; steps once per
// accepted item and presents the result of that step.
// ----------------------------------------------------------------------------
`default_nettype none

module lccd_seq
	import lccd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic                func,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire cfg_t                cfg,
	output result_t                  res
);

	localparam int INC_W = COUNT_WIDTH + 1;
	localparam int CMP_W = (INC_W > SIG_W) ? INC_W : SIG_W;

	phase_t                 phase_q, phase_nxt;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_nxt;
	logic                   icg_q, icg_nxt;
	logic                   illum_q, illum_nxt;

	logic [SIG_W-1:0]       seg_len;
	logic [INC_W-1:0]       cnt_inc;
	logic                   seg_end;
	logic [COUNT_WIDTH-1:0] cnt_seg;
	logic                   pix_valid;
	logic                   done;

	// length of the counted segment of the current phase
	always_comb begin
		case (phase_q)
			PH_DUMMY:    seg_len = SIG_W'(cfg.lead);
			PH_SHIELDED: seg_len = SIG_W'(cfg.shielded);
			PH_HEADER:   seg_len = SIG_W'(cfg.header);
			PH_SIGNAL:   seg_len = cfg.signal;
			PH_TRAIL:    seg_len = SIG_W'(cfg.trail);
			default:     seg_len = '0;
		endcase
	end

	assign cnt_inc = INC_W'(cnt_q) + INC_W'(1);
	assign seg_end = (CMP_W'(cnt_inc) >= CMP_W'(seg_len)) || cnt_inc[COUNT_WIDTH];
	assign cnt_seg = seg_end ? '0 : cnt_inc[COUNT_WIDTH-1:0];

	always_comb begin
		phase_nxt = phase_q;
		cnt_nxt   = cnt_q;
		icg_nxt   = icg_q;
		illum_nxt = illum_q;
		pix_valid = 1'b0;
		done      = 1'b0;
		if (func == FUNC_START) begin
			if (phase_q == PH_IDLE) begin
				illum_nxt = 1'b1;
				icg_nxt   = 1'b0;
				cnt_nxt   = '0;
				phase_nxt = PH_BEGIN;
			end
		end else begin
			case (phase_q)
				PH_BEGIN: begin
					phase_nxt = PH_ACTIVE;
				end
				PH_ACTIVE: begin
					icg_nxt   = 1'b1;
					cnt_nxt   = '0;
					phase_nxt = PH_DUMMY;
				end
				PH_DUMMY: begin
					cnt_nxt = cnt_seg;
					if (seg_end) phase_nxt = PH_SHIELDED;
				end
				PH_SHIELDED: begin
					cnt_nxt = cnt_seg;
					if (seg_end) phase_nxt = PH_HEADER;
				end
				PH_HEADER: begin
					cnt_nxt = cnt_seg;
					if (seg_end) phase_nxt = PH_SIGNAL;
				end
				PH_SIGNAL: begin
					pix_valid = 1'b1;
					cnt_nxt   = cnt_seg;
					if (seg_end) phase_nxt = PH_TRAIL;
				end
				PH_TRAIL: begin
					cnt_nxt = cnt_seg;
					if (seg_end) begin
						icg_nxt   = 1'b0;
						phase_nxt = PH_INTEG;
					end
				end
				PH_INTEG: begin
					phase_nxt = PH_FINISH;
				end
				PH_FINISH: begin
					illum_nxt = 1'b0;
					icg_nxt   = 1'b1;
					cnt_nxt   = '0;
					phase_nxt = PH_IDLE;
					done      = 1'b1;
				end
				default: begin
					phase_nxt = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			icg_q   <= 1'b1;
			illum_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_nxt;
			cnt_q   <= cnt_nxt;
			icg_q   <= icg_nxt;
			illum_q <= illum_nxt;
		end
	end

	always_comb begin
		res.icg       = icg_nxt;
		res.illum     = illum_nxt;
		res.phase     = phase_code(phase_nxt);
		res.pix_valid = pix_valid;
		res.pix_index = pix_valid ? PIX_W'({{PIX_W{1'b0}}, cnt_q}) : '0;
		res.pix_value = pix_valid ? sample : '0;
		res.done      = done;
	end

endmodule

`default_nettype wire

// File: rtl/linear_ccd_readout_sequencer.sv
// ----------------------------------------------------------------------------
// linear_ccd_readout_sequencer: linear CCD frame readout sequencer
// Steps through the readout phases of one frame on shift-gate ticks,
// drives ICG and illuminator, and passes out signal pixels with index.
//
// channel  signals                                        direction
// cfg      cfg_valid cfg_ready cfg_index cfg_data         in
// in       in_valid in_ready func sample                  in
// out      out_valid out_ready icg_level illuminator_on   out
//          phase pixel_valid pixel_index pixel_value
//          frame_done
//
// one item per cycle; each result appears in the cycle after its transfer,
// held in a single output register
// in_ready is low only while that register is full and out_ready is low
// cfg_ready is always high; reset restores the default segment lengths
// ----------------------------------------------------------------------------
`default_nettype none

module linear_ccd_readout_sequencer
	import lccd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  func,
	input  wire logic [SAMPLE_W-1:0]   sample,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       icg_level,
	output logic                       illuminator_on,
	output logic [PHASE_W-1:0]         phase,
	output logic                       pixel_valid,
	output logic [PIX_W-1:0]           pixel_index,
	output logic [SAMPLE_W-1:0]        pixel_value,
	output logic                       frame_done
);

	cfg_t    cfg_q;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    in_xfer;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead     <= LEAD_RST;
			cfg_q.shielded <= SHIELDED_RST;
			cfg_q.header   <= HEADER_RST;
			cfg_q.signal   <= SIGNAL_RST;
			cfg_q.trail    <= TRAIL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LEAD:     cfg_q.lead     <= cfg_data[SEG_W-1:0];
				REG_SHIELDED: cfg_q.shielded <= cfg_data[SEG_W-1:0];
				REG_HEADER:   cfg_q.header   <= cfg_data[SEG_W-1:0];
				REG_SIGNAL:   cfg_q.signal   <= cfg_data[SIG_W-1:0];
				REG_TRAIL:    cfg_q.trail    <= cfg_data[SEG_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	lccd_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_xfer),
		.func   (func),
		.sample (sample),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign icg_level      = res_q.icg;
	assign illuminator_on = res_q.illum;
	assign phase          = res_q.phase;
	assign pixel_valid    = res_q.pix_valid;
	assign pixel_index    = res_q.pix_index;
	assign pixel_value    = res_q.pix_value;
	assign frame_done     = res_q.done;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output register");

	a_illum_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (illuminator_on == (phase != PHC_IDLE)))
		else $error("illuminator state disagrees with phase");

	a_pixel_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pixel_valid) |-> (phase == PHC_SIGNAL || phase == PHC_TRAIL))
		else $error("pixel reported outside signal segment");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (phase == PHC_IDLE && icg_level && !pixel_valid))
		else $error("frame end without return to idle");

endmodule

`default_nettype wire
